[src/matc_pkg.sv]
package matc_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;
    localparam logic AGE_REMOVE   = 1'b0;

    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_INSERTED  = 3'd1,
        STS_DROPPED   = 3'd2,
        STS_REMOVED   = 3'd3,
        STS_KEPT      = 3'd4,
        STS_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [47:0] mac_address;
        logic [7:0]  port_number;
        logic [11:0] vlan_id;
        logic        static_flag;
        logic        age_flag;
        logic        valid_flag;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] entry_count;
    } t_out_item;

    // flags: bit0 static, bit1 age, bit2 valid
    typedef struct packed {
        logic        used;
        logic [47:0] mac_address;
        logic [7:0]  port_number;
        logic [11:0] vlan_id;
        logic [2:0]  flags;
    } t_entry;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic scan_en;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
    } t_dp_sts;

endpackage

[src/mac_address_table_cache.sv]
// An accepted item is registered, then the table is scanned over the window (the
// configured size, saturated at TABLE_DEPTH) up to the first matching slot, then the
// result is committed and held until taken. The table memory is read one slot per cycle
// in the scan. An empty window scans no slots. Only one item is in flight: a new item is
// accepted once the last result is taken. Reset (synchronous, active low) clears the
// entry count and clears all TABLE_DEPTH slots, one per cycle, before the first item.
module mac_address_table_cache
    import matc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    matc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    matc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_item  (o_out_item)
    );

endmodule

[src/matc_ctrl.sv]
module matc_ctrl
    import matc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    input  t_dp_sts   i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_in_ready,
    output logic      o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[src/matc_dp.sv]
module matc_dp
    import matc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_item         i_in_item,
    input  t_ctrl_cmd        i_cmd,
    output t_dp_sts          o_sts,
    output t_out_item        o_out_item
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    logic [CFG_W-1:0] r_cfg;
    t_in_item         r_item;
    logic [CW-1:0]    r_clr_idx;
    logic [CW-1:0]    r_rd_idx;
    logic [AW-1:0]    r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic             r_free_vld;
    logic [AW-1:0]    r_free_idx;
    logic [CW-1:0]    r_count;
    t_status          r_status;

    logic [CW-1:0] lim;
    logic          clr_done;
    logic          rd_more;
    logic          cmp_hit;
    logic          cmp_free;
    logic          n_we;
    logic [AW-1:0] n_wa;
    t_entry        n_wd;
    t_status       n_status;
    logic [CW-1:0] n_count;
    logic [31:0]   count_ext;

    // window saturates at the table depth
    always_comb begin
        if (32'(r_cfg) > 32'(TABLE_DEPTH)) begin
            lim = DEPTH_C;
        end else begin
            lim = CW'(r_cfg);
        end
    end

    assign clr_done = (r_clr_idx == DEPTH_C);
    assign rd_more  = (r_rd_idx < lim);
    assign cmp_hit  = r_cmp_vld && r_rd_data.used &&
                      (r_rd_data.mac_address == r_item.mac_address);
    assign cmp_free = r_cmp_vld && !r_rd_data.used;

    assign o_sts.clr_done  = clr_done;
    assign o_sts.scan_done = r_hit || (!rd_more && !r_cmp_vld);

    always_comb begin
        n_we     = 1'b0;
        n_wa     = r_clr_idx[AW-1:0];
        n_wd     = '0;
        n_status = r_status;
        n_count  = r_count;
        if (i_cmd.clr_en) begin
            n_we = !clr_done;
        end else if (i_cmd.commit) begin
            n_wd.used        = 1'b1;
            n_wd.mac_address = r_item.mac_address;
            n_wd.port_number = r_item.port_number;
            n_wd.vlan_id     = r_item.vlan_id;
            n_wd.flags       = {r_item.valid_flag, r_item.age_flag, r_item.static_flag};
            if (r_item.kind == KIND_ADD) begin
                if (r_hit) begin
                    n_we     = 1'b1;
                    n_wa     = r_hit_idx;
                    n_status = STS_UPDATED;
                end else if (r_free_vld) begin
                    n_we     = 1'b1;
                    n_wa     = r_free_idx;
                    n_count  = r_count + 1'b1;
                    n_status = STS_INSERTED;
                end else begin
                    n_status = STS_DROPPED;
                end
            end else begin
                if (!r_hit) begin
                    n_status = STS_NOT_FOUND;
                end else if (r_item.age_flag == AGE_REMOVE) begin
                    n_we      = 1'b1;
                    n_wa      = r_hit_idx;
                    n_wd.used = 1'b0;
                    if (r_count != '0) n_count = r_count - 1'b1;
                    n_status  = STS_REMOVED;
                end else begin
                    n_status = STS_KEPT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_clr_idx  <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (i_cmd.clr_en && !clr_done) r_clr_idx <= r_clr_idx + 1'b1;
            r_count <= n_count;
            if (i_cmd.load) begin
                r_rd_idx   <= '0;
                r_cmp_vld  <= 1'b0;
                r_hit      <= 1'b0;
                r_free_vld <= 1'b0;
            end else if (i_cmd.scan_en) begin
                // read issue runs one entry ahead of the compare
                r_cmp_vld <= rd_more && !r_hit;
                if (rd_more) r_rd_idx <= r_rd_idx + 1'b1;
                if (cmp_hit && !r_hit) r_hit <= 1'b1;
                if (cmp_free && !r_free_vld) r_free_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_item;
        if (i_cmd.scan_en) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
            if (cmp_hit && !r_hit) r_hit_idx <= r_cmp_idx;
            if (cmp_free && !r_free_vld) r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) r_status <= n_status;
    end

    assign count_ext              = 32'(r_count);
    assign o_out_item.status      = r_status;
    assign o_out_item.entry_count = count_ext[6:0];

endmodule

[src/matc_checker.sv]
module matc_checker
    import matc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed or dropped while stalled");

    // one item in flight: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= STS_NOT_FOUND)
        else $error("undefined status code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake active right after reset");

endmodule

bind mac_address_table_cache matc_checker u_matc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
